// ----- hdl/bb_pkg.sv -----
`default_nettype none
// ============================================================================
// bb_pkg
// Shared widths, types and tables of the 3x3 RGB box blur.
// ============================================================================
package bb_pkg;

    // Default line length in pixels.
    localparam int DEF_MAX_WIDTH = 1024;

    // Configuration port.
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W      = 16;
    localparam int ROW_W         = HEIGHT_W + 1;
    localparam int RESET_WIDTH   = 1024;
    localparam int RESET_HEIGHT  = 1024;

    // Pixel and arithmetic widths.
    localparam int NUM_LANES   = 3;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = NUM_LANES * CHAN_W;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'd0,
        REG_FRAME_HEIGHT = 1'd1
    } cfg_reg_t;

    // Neighborhood window: [row, oldest first][column, oldest first].
    typedef logic [2:0][2:0][PIX_W-1:0]  pix_win_t;
    typedef logic [2:0][2:0][CHAN_W-1:0] chan_win_t;
    typedef logic [2:0][2:0]             mask_t;

    // Stage load enables handed to each channel lane.
    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
    } lane_ctl_t;

    // Control that travels with a result into the merging stage.
    typedef struct packed {
        logic valid;
        logic frame_end;
    } res_ctl_t;

    // Reciprocal ceil(2^18 / (2n)) for every neighbor count that can occur.
    // With a numerator below 2^13 the product shifted right by 18 is exact.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/bb_line_store.sv -----
`default_nettype none
// ============================================================================
// bb_line_store
// Two previous rows of pixels kept as one wide word per column, with a
// registered read port and write-to-read bypass on a matching address.
// ============================================================================
module bb_line_store #(
    parameter int DEPTH  = bb_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [2*bb_pkg::PIX_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [2*bb_pkg::PIX_W-1:0] rd_data
);
    import bb_pkg::*;

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a same-cycle write to the read address is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hdl/bb_lane.sv -----
`default_nettype none
// ============================================================================
// bb_lane
// One color channel: masked sum of the 3x3 window, then the rounded mean
// by multiplication with the reciprocal of twice the neighbor count.
// ============================================================================
module bb_lane (
    input  wire logic                         clk,
    input  wire bb_pkg::lane_ctl_t            ctl,
    input  wire bb_pkg::chan_win_t            pix,
    input  wire bb_pkg::mask_t                mask,
    input  wire logic [bb_pkg::CNT_W-1:0]     count,
    input  wire logic [bb_pkg::RECIP_W-1:0]   recip_val,
    output logic      [bb_pkg::CHAN_W-1:0]    quot
);
    import bb_pkg::*;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // Sum of the neighbors that lie inside the frame.
    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_next = sum_next + (mask[r][c] ? SUM_W'(pix[r][c]) : '0);
            end
        end
    end

    // Rounded mean (2*sum + n) / (2*n) as a product with the reciprocal.
    assign num       = {sum_reg, 1'b0} + NUM_W'(count);
    assign prod_next = PROD_W'(num) * PROD_W'(recip_val);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.ld_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign quot = prod_reg[RECIP_SHIFT +: CHAN_W];

endmodule
`default_nettype wire

// ----- hdl/bb_merge.sv -----
`default_nettype none
// ============================================================================
// bb_merge
// Output register: joins the three channel results and the end-of-frame
// flag into one result request.
// ============================================================================
module bb_merge (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire bb_pkg::res_ctl_t                              res,
    input  wire logic [bb_pkg::NUM_LANES-1:0][bb_pkg::CHAN_W-1:0] quot,
    input  wire logic                                          out_stall,
    output logic                                               out_valid,
    output logic      [bb_pkg::CHAN_W-1:0]                     out_red,
    output logic      [bb_pkg::CHAN_W-1:0]                     out_green,
    output logic      [bb_pkg::CHAN_W-1:0]                     out_blue,
    output logic                                               frame_end,
    output logic                                               out_ready
);
    import bb_pkg::*;

    logic                                out_valid_reg;
    logic [NUM_LANES-1:0][CHAN_W-1:0]    quot_reg;
    logic                                frame_end_reg;

    // The register takes a new request when empty or being drained.
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res.valid)
        begin
            quot_reg      <= quot;
            frame_end_reg <= res.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = quot_reg[0];
    assign out_green = quot_reg[1];
    assign out_blue  = quot_reg[2];
    assign frame_end = frame_end_reg;

endmodule
`default_nettype wire

// ----- hdl/box_blur_3x3_rgb.sv -----
`default_nettype none
// ============================================================================
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB frame in raster order.
// ============================================================================
// The block takes one request per clock while the output side keeps up and
// gives each pixel's blur, per channel the rounded-half-up mean of its 1 to 9
// in-frame neighbors. A result trails its pixel by one row and one pixel
// (width + 1 requests); after the last pixel send width + 1 drain requests,
// the last of which releases the result flagged frame_end. The result of a
// request is held in the window, loaded at the edge that takes it, then in
// the sum, product and output registers. Throughput is one request per
// clock while the output side keeps up, set by the single line-store memory
// (one write and one read a clock, read one column ahead). The line store
// needs no clearing after reset. Write frame_width and frame_height only
// while the block is idle; any write restarts the frame.
// ============================================================================
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bb_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bb_pkg::CHAN_W-1:0]       in_red,
    input  wire logic [bb_pkg::CHAN_W-1:0]       in_green,
    input  wire logic [bb_pkg::CHAN_W-1:0]       in_blue,
    input  wire logic                            drain,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [bb_pkg::CHAN_W-1:0]       out_red,
    output logic      [bb_pkg::CHAN_W-1:0]       out_green,
    output logic      [bb_pkg::CHAN_W-1:0]       out_blue,
    output logic                                 frame_end
);
    import bb_pkg::*;

    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RESET_EFF_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam logic [COL_W-1:0]    RESET_LAST_COL = COL_W'(RESET_EFF_W - 1);
    localparam logic [HEIGHT_W-1:0] RESET_LAST_ROW = HEIGHT_W'(RESET_HEIGHT - 1);

    // Frame geometry, held as last column and last row.
    logic [COL_W-1:0]    last_col_reg, last_col_next;
    logic [HEIGHT_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0]    cfg_last_col;
    logic [HEIGHT_W-1:0] cfg_last_row;

    // Input and output positions.
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;

    // Window and pipeline stages.
    pix_win_t            win_reg, win_next;
    logic                s1_valid_reg;
    logic [2:0]          row_mask_reg;
    logic [2:0]          col_mask_reg;
    logic                s1_end_reg;
    logic                s2_valid_reg;
    logic [CNT_W-1:0]    s2_count_reg;
    logic                s2_end_reg;
    logic                s3_valid_reg;
    logic                s3_end_reg;

    logic                s1_ready, s2_ready, s3_ready, out_ready;
    logic                is_pixel, emit, take, take_eff, end_now;
    logic [PIX_W-1:0]    pix_in;
    logic [2*PIX_W-1:0]  rd_data;
    logic [PIX_W-1:0]    rd_up, rd_mid;
    mask_t               win_mask;
    logic [CNT_W-1:0]    win_count;
    lane_ctl_t           lane_ctl;
    res_ctl_t            res_ctl;
    logic [NUM_LANES-1:0][CHAN_W-1:0] lane_q;

    // Pipeline flow: a stage moves on when empty or when the next one moves.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // Request classification.
    assign is_pixel = (in_row_reg <= ROW_W'(last_row_reg));
    assign emit     = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign take     = in_valid && !in_stall;
    assign take_eff = take && !(drain && is_pixel) && !cfg_wr_en;
    assign end_now  = emit && (out_row_reg == last_row_reg) && (out_col_reg == last_col_reg);
    assign pix_in   = is_pixel ? {in_red, in_green, in_blue} : '0;
    assign rd_up    = rd_data[2*PIX_W-1:PIX_W];
    assign rd_mid   = rd_data[PIX_W-1:0];

    // Register values decoded from a configuration write.
    always_comb
    begin
        int wv;
        int eff;
        wv  = int'(cfg_data[WIDTH_FIELD_W-1:0]);
        eff = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
        cfg_last_col = COL_W'(eff - 1);
        cfg_last_row = (cfg_data[HEIGHT_W-1:0] == '0) ? '0
                     : cfg_data[HEIGHT_W-1:0] - HEIGHT_W'(1);
    end

    // Next state of geometry, positions and window.
    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        win_next      = win_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  last_col_next = cfg_last_col;
                REG_FRAME_HEIGHT: last_row_next = cfg_last_row;
                default:          ;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take_eff)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = rd_up;
            win_next[1][2] = rd_mid;
            win_next[2][2] = pix_in;
            if (end_now)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (emit)
                begin
                    if (out_col_reg == last_col_reg)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + HEIGHT_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
                if (in_col_reg == last_col_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= RESET_LAST_COL;
            last_row_reg <= RESET_LAST_ROW;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            if (s1_ready)
            begin
                s1_valid_reg <= take_eff && emit;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Window and stage payload.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (take_eff)
        begin
            row_mask_reg <= {out_row_reg != last_row_reg, 1'b1, out_row_reg != '0};
            col_mask_reg <= {out_col_reg != last_col_reg, 1'b1, out_col_reg != '0};
            s1_end_reg   <= end_now;
        end
        if (s2_ready)
        begin
            s2_count_reg <= win_count;
            s2_end_reg   <= s1_end_reg;
        end
        if (s3_ready)
        begin
            s3_end_reg <= s2_end_reg;
        end
    end

    // Line store: upper row and middle row of one column per word.
    bb_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (take_eff),
        .wr_addr (in_col_reg),
        .wr_data ({rd_mid, pix_in}),
        .rd_addr (in_col_next),
        .rd_data (rd_data)
    );

    // Neighbor mask and count shared by the lanes.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                win_mask[r][c] = row_mask_reg[r] && col_mask_reg[c];
            end
        end
    end

    assign win_count        = CNT_W'($countones(win_mask));
    assign lane_ctl.ld_sum  = s2_ready;
    assign lane_ctl.ld_prod = s3_ready;

    // One lane per color channel, red first.
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        chan_win_t lane_pix;

        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lane_pix[r][c] = win_reg[r][c][PIX_W-1-l*CHAN_W -: CHAN_W];
                end
            end
        end

        bb_lane u_lane (
            .clk       (clk),
            .ctl       (lane_ctl),
            .pix       (lane_pix),
            .mask      (win_mask),
            .count     (s2_count_reg),
            .recip_val (recip(s2_count_reg)),
            .quot      (lane_q[l])
        );
    end

    assign res_ctl.valid     = s3_valid_reg;
    assign res_ctl.frame_end = s3_end_reg;

    // Merging stage and output register.
    bb_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res_ctl),
        .quot      (lane_q),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .frame_end (frame_end),
        .out_ready (out_ready)
    );

`ifndef SYNTH
    // Positions stay inside the configured row.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg <= last_col_reg) && (out_col_reg <= last_col_reg))
        else $error("column position beyond frame width");

    // The result position never runs ahead of the input position.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        ROW_W'(out_row_reg) <= in_row_reg)
        else $error("output row ahead of input row");

    // A drain request while pixels are still due leaves the positions alone.
    a_drain_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (take && drain && is_pixel && !cfg_wr_en)
        |=> ($stable(in_col_reg) && $stable(in_row_reg) && !s1_valid_reg))
        else $error("ignored drain request changed state");

    // The last result of a frame restarts all positions.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take_eff && end_now)
        |=> ((in_col_reg == '0) && (in_row_reg == '0)
             && (out_col_reg == '0) && (out_row_reg == '0)))
        else $error("frame did not restart after its last result");
`endif

endmodule
`default_nettype wire
